[sv/fmrt_pkg.sv]
// ----------------------------------------------------------------------------
// fmrt_pkg
// Shared types, register map constants and decode helpers for the FM synth
// register command front end.
// ----------------------------------------------------------------------------
package fmrt_pkg;

  // Shadow store: one byte per chip register on each of the two ports
  localparam int unsigned ShadowDepth = 512;
  localparam int unsigned ShadowAw    = $clog2(ShadowDepth);

  // Command codes
  typedef enum logic [3:0] {
    OpKeyOn        = 4'd0,
    OpKeyOff       = 4'd1,
    OpAlgorithm    = 4'd2,
    OpFeedback     = 4'd3,
    OpStereo       = 4'd4,
    OpMultiple     = 4'd5,
    OpDetune       = 4'd6,
    OpLevel        = 4'd7,
    OpAttack       = 4'd8,
    OpDecay        = 4'd9,
    OpSustainLevel = 4'd10,
    OpSustainRate  = 4'd11,
    OpRelease      = 4'd12,
    OpKeyScale     = 4'd13,
    OpRaw          = 4'd14
  } op_e;

  // Chip register map
  localparam logic [7:0] AddrFnumHi = 8'ha4;
  localparam logic [7:0] AddrFnumLo = 8'ha0;
  localparam logic [7:0] AddrKey    = 8'h28;
  localparam logic [7:0] KeyOnMask  = 8'hf0;
  localparam logic [7:0] AddrFbAlg  = 8'hb0;
  localparam logic [7:0] AddrStereo = 8'hb4;
  localparam logic [7:0] AddrDtMul  = 8'h30;
  localparam logic [7:0] AddrTl     = 8'h40;
  localparam logic [7:0] AddrKsAr   = 8'h50;
  localparam logic [7:0] AddrDr     = 8'h60;
  localparam logic [7:0] AddrSr     = 8'h70;
  localparam logic [7:0] AddrSlRr   = 8'h80;

  localparam logic [6:0] MaxKey     = 7'd95;
  localparam logic [2:0] MaxChannel = 3'd5;

  // Reciprocal of twelve for key splitting: key * 171 >> 11 == key / 12
  localparam logic [7:0] RecipTwelve = 8'd171;

  // One decoded command: target write and merge masks
  typedef struct packed {
    logic [1:0] count;   // writes this command emits
    logic       merge;   // read-modify-write through the shadow
    logic       port;
    logic [7:0] addr;
    logic [7:0] keep;    // bits kept from the shadow byte
    logic [7:0] bits;    // new field bits (or whole byte when keep is zero)
  } cmd_t;

  // Shadow write request
  typedef struct packed {
    logic                en;
    logic [ShadowAw-1:0] addr;
    logic [7:0]          data;
  } wr_t;

  // Up to three register writes for the output sequencer
  typedef struct packed {
    logic [1:0]      count;
    logic            port;
    logic [2:0][7:0] addr;
    logic [2:0][7:0] data;
  } burst_t;

  // F-number per note within an octave
  function automatic logic [10:0] fnum_lookup(input logic [3:0] note);
    logic [10:0] fn;
    case (note)
      4'd0:    fn = 11'd654;
      4'd1:    fn = 11'd693;
      4'd2:    fn = 11'd734;
      4'd3:    fn = 11'd778;
      4'd4:    fn = 11'd824;
      4'd5:    fn = 11'd873;
      4'd6:    fn = 11'd925;
      4'd7:    fn = 11'd980;
      4'd8:    fn = 11'd1038;
      4'd9:    fn = 11'd1100;
      4'd10:   fn = 11'd1165;
      4'd11:   fn = 11'd1235;
      default: fn = 11'd654;
    endcase
    return fn;
  endfunction

  // Map a command to its target register, masks and write count
  function automatic cmd_t decode_cmd(input logic [3:0] op,
                                      input logic [2:0] ch,
                                      input logic [1:0] oper,
                                      input logic [6:0] val,
                                      input logic       raw_port,
                                      input logic [7:0] raw_addr,
                                      input logic [7:0] raw_data);
    cmd_t       c;
    logic       hi;
    logic [1:0] slot;
    logic [7:0] off;
    hi   = (ch >= 3'd3);
    slot = hi ? 2'(ch - 3'd3) : ch[1:0];
    off  = {4'b0, oper, slot};
    c       = '0;
    c.port  = hi;
    c.count = 2'd1;
    unique case (op)
      OpKeyOn: begin
        c.count = (val > MaxKey) ? 2'd0 : 2'd3;
        c.addr  = AddrFnumHi + {6'b0, slot};
      end
      OpKeyOff: begin
        c.addr = AddrKey;
        c.bits = {5'b0, ch};
      end
      OpAlgorithm: begin
        c.merge = 1'b1;
        c.addr  = AddrFbAlg + {6'b0, slot};
        c.keep  = 8'hf8;
        c.bits  = {5'b0, val[2:0]};
      end
      OpFeedback: begin
        c.merge = 1'b1;
        c.addr  = AddrFbAlg + {6'b0, slot};
        c.keep  = 8'hc7;
        c.bits  = {2'b0, val[2:0], 3'b0};
      end
      OpStereo: begin
        c.merge = 1'b1;
        c.addr  = AddrStereo + {6'b0, slot};
        c.keep  = 8'h3f;
        c.bits  = {val[1:0], 6'b0};
      end
      OpMultiple: begin
        c.merge = 1'b1;
        c.addr  = AddrDtMul + off;
        c.keep  = 8'hf0;
        c.bits  = {4'b0, val[3:0]};
      end
      OpDetune: begin
        c.merge = 1'b1;
        c.addr  = AddrDtMul + off;
        c.keep  = 8'h8f;
        c.bits  = {1'b0, val[2:0], 4'b0};
      end
      OpLevel: begin
        c.addr = AddrTl + off;
        c.bits = {1'b0, val};
      end
      OpAttack: begin
        c.merge = 1'b1;
        c.addr  = AddrKsAr + off;
        c.keep  = 8'he0;
        c.bits  = {3'b0, val[4:0]};
      end
      OpDecay: begin
        c.merge = 1'b1;
        c.addr  = AddrDr + off;
        c.keep  = 8'he0;
        c.bits  = {3'b0, val[4:0]};
      end
      OpSustainLevel: begin
        c.merge = 1'b1;
        c.addr  = AddrSlRr + off;
        c.keep  = 8'h0f;
        c.bits  = {val[3:0], 4'b0};
      end
      OpSustainRate: begin
        c.addr = AddrSr + off;
        c.bits = {3'b0, val[4:0]};
      end
      OpRelease: begin
        c.merge = 1'b1;
        c.addr  = AddrSlRr + off;
        c.keep  = 8'hf0;
        c.bits  = {4'b0, val[3:0]};
      end
      OpKeyScale: begin
        c.merge = 1'b1;
        c.addr  = AddrKsAr + off;
        c.keep  = 8'h3f;
        c.bits  = {val[1:0], 6'b0};
      end
      OpRaw: begin
        c.port = raw_port;
        c.addr = raw_addr;
        c.bits = raw_data;
      end
      default: begin
        c.count = 2'd0;
      end
    endcase
    // Channels six and seven are dropped on everything but raw writes
    if (op != OpRaw && ch > MaxChannel) begin
      c.count = 2'd0;
      c.merge = 1'b0;
    end
    if (c.count == 2'd0) begin
      c.merge = 1'b0;
    end
    return c;
  endfunction

endpackage

[sv/fmrt_shadow_ram.sv]
// ----------------------------------------------------------------------------
// fmrt_shadow_ram
// Shadow copy of the chip registers, one read and one write port, registered
// read data. Swept to zero one entry per cycle after reset.
// ----------------------------------------------------------------------------
module fmrt_shadow_ram
  import fmrt_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                rd_en_i,
  input  logic [ShadowAw-1:0] rd_addr_i,
  output logic [7:0]          rd_data_o,
  input  wr_t                 wr_i,
  output logic                clr_busy_o
);

  logic [7:0]          mem_q [ShadowDepth];
  logic [7:0]          rd_data_q;
  logic                clr_q;
  logic [ShadowAw-1:0] clr_cnt_q;

  // Clearing sweep control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else if (clr_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == ShadowAw'(ShadowDepth - 1)) begin
        clr_q <= 1'b0;
      end
    end
  end

  // Storage array, write before nothing: read returns the old byte
  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      mem_q[clr_cnt_q] <= 8'h00;
    end else if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o  = rd_data_q;
  assign clr_busy_o = clr_q;

endmodule

[sv/fmrt_exec.sv]
// ----------------------------------------------------------------------------
// fmrt_exec
// Command register and single-pass execute: shadow merge, key on split and
// F-number lookup, shadow write back with forwarding to the next command.
// ----------------------------------------------------------------------------
module fmrt_exec
  import fmrt_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  logic [3:0]          opcode_i,
  input  logic [2:0]          channel_i,
  input  logic [1:0]          operator_index_i,
  input  logic [6:0]          param_value_i,
  input  logic                raw_port_i,
  input  logic [7:0]          raw_address_i,
  input  logic [7:0]          raw_data_i,
  output logic [ShadowAw-1:0] rd_addr_o,
  input  logic [7:0]          rd_data_i,
  input  logic                ob_ready_i,
  output logic                valid_o,
  output logic                advance_o,
  output wr_t                 wr_o,
  output logic                burst_load_o,
  output burst_t              burst_o
);

  logic        valid_q;
  logic [3:0]  op_q;
  logic [2:0]  ch_q;
  logic [1:0]  oper_q;
  logic [6:0]  val_q;
  logic        raw_port_q;
  logic [7:0]  raw_addr_q;
  logic [7:0]  raw_data_q;
  logic        fwd_q;
  logic [7:0]  fwd_data_q;

  cmd_t        cmd_in;
  cmd_t        cmd_s;
  logic [7:0]  old_byte;
  logic [7:0]  merged;
  logic [14:0] key_prod;
  logic [3:0]  blk;
  logic [3:0]  note;
  logic [10:0] fn;

  // Read address of the incoming command
  always_comb begin
    cmd_in    = decode_cmd(opcode_i, channel_i, operator_index_i, param_value_i,
                           raw_port_i, raw_address_i, raw_data_i);
    rd_addr_o = {cmd_in.port, cmd_in.addr};
  end

  // Merge with the shadow byte, forwarded if the previous command wrote it
  always_comb begin
    cmd_s    = decode_cmd(op_q, ch_q, oper_q, val_q, raw_port_q, raw_addr_q, raw_data_q);
    old_byte = fwd_q ? fwd_data_q : rd_data_i;
    merged   = (old_byte & cmd_s.keep) | (cmd_s.bits & ~cmd_s.keep);
  end

  // Key split into octave and note
  always_comb begin
    key_prod = 15'(val_q) * 15'(RecipTwelve);
    blk      = key_prod[14:11];
    note     = 4'(val_q - 7'({blk, 3'b0}) - 7'({blk, 2'b0}));
    fn       = fnum_lookup(note);
  end

  // Write list for the output sequencer
  always_comb begin
    burst_o         = '0;
    burst_o.count   = cmd_s.count;
    burst_o.port    = cmd_s.port;
    burst_o.addr[0] = cmd_s.addr;
    if (op_q == OpKeyOn) begin
      burst_o.data[0] = {2'b0, blk[2:0], fn[10:8]};
      burst_o.addr[1] = AddrFnumLo | {6'b0, cmd_s.addr[1:0]};
      burst_o.data[1] = fn[7:0];
      burst_o.addr[2] = AddrKey;
      burst_o.data[2] = KeyOnMask | {5'b0, ch_q};
    end else begin
      burst_o.data[0] = merged;
    end
  end

  assign advance_o    = valid_q & ((cmd_s.count == 2'd0) | ob_ready_i);
  assign burst_load_o = valid_q & (cmd_s.count != 2'd0) & ob_ready_i;
  assign valid_o      = valid_q;

  always_comb begin
    wr_o.en   = advance_o & cmd_s.merge;
    wr_o.addr = {cmd_s.port, cmd_s.addr};
    wr_o.data = merged;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      fwd_q   <= 1'b0;
    end else begin
      valid_q <= load_i | (valid_q & ~advance_o);
      if (load_i) begin
        fwd_q <= wr_o.en & (wr_o.addr == rd_addr_o);
      end
    end
  end

  // Command payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      op_q       <= opcode_i;
      ch_q       <= channel_i;
      oper_q     <= operator_index_i;
      val_q      <= param_value_i;
      raw_port_q <= raw_port_i;
      raw_addr_q <= raw_address_i;
      raw_data_q <= raw_data_i;
      fwd_data_q <= wr_o.data;
    end
  end

endmodule

[sv/fmrt_out.sv]
// ----------------------------------------------------------------------------
// fmrt_out
// Output register and write sequencer: plays out one to three register
// writes of a command, flagging the final one.
// ----------------------------------------------------------------------------
module fmrt_out
  import fmrt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  burst_t     burst_i,
  output logic       ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       bus_port_o,
  output logic [7:0] reg_address_o,
  output logic [7:0] reg_data_o,
  output logic       last_write_o
);

  logic       valid_q;
  logic [1:0] idx_q;
  burst_t     buf_q;
  logic       last;

  assign last    = (idx_q == buf_q.count - 2'd1);
  assign ready_o = ~valid_q | (out_ready_i & last);

  // Sequencer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (load_i) begin
      valid_q <= 1'b1;
      idx_q   <= '0;
    end else if (valid_q && out_ready_i) begin
      if (last) begin
        valid_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  // Write list payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      buf_q <= burst_i;
    end
  end

  assign out_valid_o   = valid_q;
  assign bus_port_o    = buf_q.port;
  assign reg_address_o = buf_q.addr[idx_q];
  assign reg_data_o    = buf_q.data[idx_q];
  assign last_write_o  = last;

endmodule

[sv/fm_synth_register_command_translator_unit.sv]
// ----------------------------------------------------------------------------
// fm_synth_register_command_translator_unit
// FM synth command front end: turns key and parameter commands into chip
// register writes, merging bit fields through a shadow register copy.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-------------------------------
//   in      | input     | in_valid_i/in_ready_o | opcode, channel, operator_index,
//           |           |                       | param_value, raw_port/address/data
//   out     | output    | out_valid_o/out_ready_i | bus_port, reg_address, reg_data,
//           |           |                       | last_write
//
// A command can be accepted every cycle while the output sequencer is ready; its
// first write passes the command register, then the output register. Single-write
// commands sustain one per cycle; key on holds the output sequencer for its three
// writes, issued one per cycle. After reset the shadow store is swept to zero
// with in_ready_o low. A stalled output holds its write; the command register
// then holds and in_ready_o drops. A command emitting nothing skips the output.
// ----------------------------------------------------------------------------
module fm_synth_register_command_translator_unit
  import fmrt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [3:0] opcode_i,
  input  logic [2:0] channel_i,
  input  logic [1:0] operator_index_i,
  input  logic [6:0] param_value_i,
  input  logic       raw_port_i,
  input  logic [7:0] raw_address_i,
  input  logic [7:0] raw_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       bus_port_o,
  output logic [7:0] reg_address_o,
  output logic [7:0] reg_data_o,
  output logic       last_write_o
);

  logic                accept;
  logic                clr_busy;
  logic [ShadowAw-1:0] rd_addr;
  logic [7:0]          rd_data;
  wr_t                 wr;
  logic                s_valid;
  logic                s_adv;
  logic                ob_ready;
  logic                burst_load;
  burst_t              burst;

  // Input transfer
  assign in_ready_o = ~clr_busy & (~s_valid | s_adv);
  assign accept     = in_valid_i & in_ready_o;

  fmrt_shadow_ram u_shadow (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (accept),
    .rd_addr_i  (rd_addr),
    .rd_data_o  (rd_data),
    .wr_i       (wr),
    .clr_busy_o (clr_busy)
  );

  fmrt_exec u_exec (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .load_i           (accept),
    .opcode_i         (opcode_i),
    .channel_i        (channel_i),
    .operator_index_i (operator_index_i),
    .param_value_i    (param_value_i),
    .raw_port_i       (raw_port_i),
    .raw_address_i    (raw_address_i),
    .raw_data_i       (raw_data_i),
    .rd_addr_o        (rd_addr),
    .rd_data_i        (rd_data),
    .ob_ready_i       (ob_ready),
    .valid_o          (s_valid),
    .advance_o        (s_adv),
    .wr_o             (wr),
    .burst_load_o     (burst_load),
    .burst_o          (burst)
  );

  fmrt_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (burst_load),
    .burst_i       (burst),
    .ready_o       (ob_ready),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .bus_port_o    (bus_port_o),
    .reg_address_o (reg_address_o),
    .reg_data_o    (reg_data_o),
    .last_write_o  (last_write_o)
  );

endmodule

[sv/fmrt_checker.sv]
// ----------------------------------------------------------------------------
// fmrt_checker
// Port-level checks for the FM synth command front end, bound to the top.
// ----------------------------------------------------------------------------
module fmrt_port_checker
  import fmrt_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [3:0] opcode_i,
  input logic [2:0] channel_i,
  input logic [1:0] operator_index_i,
  input logic [6:0] param_value_i,
  input logic       raw_port_i,
  input logic [7:0] raw_address_i,
  input logic [7:0] raw_data_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       bus_port_o,
  input logic [7:0] reg_address_o,
  input logic [7:0] reg_data_o,
  input logic       last_write_o
);

  // Stalled write stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output write dropped while stalled");

  // Stalled write keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(reg_address_o) && $stable(reg_data_o)
      && $stable(bus_port_o) && $stable(last_write_o))
    else $error("output write changed while stalled");

  // Only the F-number writes of a key on are not final
  a_nonlast_fnum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_write_o |-> reg_address_o[7:3] == AddrFnumLo[7:3])
    else $error("non-final write outside the F-number registers");

  // A multi-write command continues at once on the same port
  a_burst_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_write_o
      |=> out_valid_o && bus_port_o == $past(bus_port_o))
    else $error("key on write sequence broken");

endmodule

bind fm_synth_register_command_translator_unit fmrt_port_checker u_fmrt_checker (.*);
